/* rtl/core/smpc_pkg.sv */
package smpc_pkg;

  localparam int TIME_W    = 32;
  localparam int SAMPLE_W  = 10;
  localparam int PCT_W     = 15;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int PROD_W    = SAMPLE_W + PCT_W;
  localparam int DIV_CNT_W = 4;

  localparam logic [PCT_W-1:0]     FULL_SCALE      = PCT_W'(25600);
  localparam logic [TIME_W-1:0]    MIN_PUMP_OFF_MS = TIME_W'(9000);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST        = DIV_CNT_W'(PCT_W - 1);

  localparam logic [TIME_W-1:0]   RST_SETTLING = TIME_W'(15000);
  localparam logic [TIME_W-1:0]   RST_CHECK    = TIME_W'(3600000);
  localparam logic [TIME_W-1:0]   RST_BURST    = TIME_W'(3000);
  localparam logic [TIME_W-1:0]   RST_COOLDOWN = TIME_W'(3600000);
  localparam logic [PCT_W-1:0]    RST_DRY      = PCT_W'(7680);
  localparam logic [PCT_W-1:0]    RST_WET      = PCT_W'(17920);
  localparam logic [SAMPLE_W-1:0] RST_AIR      = SAMPLE_W'(550);
  localparam logic [SAMPLE_W-1:0] RST_WATER    = SAMPLE_W'(275);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETTLING = 3'd0,
    CFG_CHECK    = 3'd1,
    CFG_BURST    = 3'd2,
    CFG_COOLDOWN = 3'd3,
    CFG_DRY      = 3'd4,
    CFG_WET      = 3'd5,
    CFG_AIR      = 3'd6,
    CFG_WATER    = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_START      = 2'd1,
    EV_STOP_WET   = 2'd2,
    EV_STOP_BURST = 2'd3
  } pump_event_t;

  typedef struct packed {
    logic [TIME_W-1:0]   settling_delay_ms;
    logic [TIME_W-1:0]   check_interval_ms;
    logic [TIME_W-1:0]   burst_duration_ms;
    logic [TIME_W-1:0]   cooldown_ms;
    logic [PCT_W-1:0]    dry_threshold;
    logic [PCT_W-1:0]    wet_threshold;
    logic [SAMPLE_W-1:0] air_reading;
    logic [SAMPLE_W-1:0] water_reading;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic load;
    logic eval;
    logic mul;
    logic div_step;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic sample;
    logic div_last;
  } sts_t;

  typedef struct packed {
    logic             pump_on;
    logic             sampled;
    logic [PCT_W-1:0] moisture_percent;
    pump_event_t      pump_event;
  } res_t;

endpackage

/* rtl/core/smpc_ctrl.sv */
module smpc_ctrl import smpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_DEC  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = sts.sample ? ST_MUL : ST_DEC;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_last) state_nxt = ST_DEC;
      ST_DEC:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.idle     = (state_r == ST_IDLE);
  assign cmd.load     = (state_r == ST_IDLE) && in_valid;
  assign cmd.eval     = (state_r == ST_EVAL);
  assign cmd.mul      = (state_r == ST_MUL);
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.decide   = (state_r == ST_DEC);
  assign cmd.emit     = (state_r == ST_FIN) && out_free;

endmodule

/* rtl/core/smpc_dp.sv */
module smpc_dp import smpc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  input  cfg_t                cfg,
  input  logic [TIME_W-1:0]   in_current_time,
  input  logic [SAMPLE_W-1:0] in_moisture_raw,
  output sts_t                sts,
  output res_t                res
);

  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                input logic [TIME_W-1:0] then_t);
    elapsed = now - then_t;
  endfunction

  // Controller state.
  logic pump_running_r, pump_running_nxt;
  logic settling_r, settling_nxt;
  logic [TIME_W-1:0] last_check_r, last_check_nxt;
  logic [TIME_W-1:0] start_time_r, start_time_nxt;
  logic [TIME_W-1:0] stop_time_r, stop_time_nxt;
  logic [TIME_W-1:0] last_water_r, last_water_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic              sampled_r, sampled_nxt;
  pump_event_t       event_r, event_nxt;

  // Working registers.
  logic [TIME_W-1:0]    now_r;
  logic [SAMPLE_W-1:0]  raw_r;
  logic                 br_run_r, br_run_nxt;
  logic                 br_check_r, br_check_nxt;
  logic                 zero_r, full_r;
  logic [SAMPLE_W-1:0]  dabs_r;
  logic [SAMPLE_W-1:0]  rem_r, rem_nxt;
  logic [PCT_W-1:0]     q_r, q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic                settle_wait, check_due, go;
  logic [DIFF_W-1:0]   n_diff, d_diff;
  logic [SAMPLE_W-1:0] n_abs, d_abs;
  logic [PROD_W-1:0]   prod;
  logic [DIFF_W-1:0]   rem_sh;
  logic                rem_ge;
  logic [PCT_W-1:0]    mapped, new_pct;

  assign settle_wait = settling_r && (elapsed(now_r, stop_time_r) < cfg.settling_delay_ms);
  assign check_due   = elapsed(now_r, last_check_r) >= cfg.check_interval_ms;
  assign go          = !settle_wait;

  assign br_run_nxt   = go && pump_running_r;
  assign br_check_nxt = go && !pump_running_r && check_due;

  assign sts.sample   = br_run_nxt || br_check_nxt;
  assign sts.div_last = (cnt_r == DIV_LAST);

  // Percent mapping: magnitudes are divided, the sign and range cases are flagged.
  assign n_diff = {1'b0, raw_r} - {1'b0, cfg.air_reading};
  assign d_diff = {1'b0, cfg.water_reading} - {1'b0, cfg.air_reading};
  assign n_abs  = n_diff[DIFF_W-1] ? SAMPLE_W'(-n_diff) : n_diff[SAMPLE_W-1:0];
  assign d_abs  = d_diff[DIFF_W-1] ? SAMPLE_W'(-d_diff) : d_diff[SAMPLE_W-1:0];
  assign prod   = PROD_W'(n_abs) * PROD_W'(FULL_SCALE);

  assign rem_sh  = {rem_r, q_r[PCT_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dabs_r};
  assign rem_nxt = cmd.mul ? prod[PROD_W-1:PCT_W] :
                   (rem_ge ? SAMPLE_W'(rem_sh - {1'b0, dabs_r}) : rem_sh[SAMPLE_W-1:0]);
  assign q_nxt   = cmd.mul ? prod[PCT_W-1:0] : {q_r[PCT_W-2:0], rem_ge};
  assign cnt_nxt = cmd.mul ? '0 : cnt_r + DIV_CNT_W'(1);

  assign mapped  = zero_r ? '0 : (full_r ? FULL_SCALE : q_r);
  assign new_pct = (br_run_r || br_check_r) ? mapped : pct_r;

  always_comb begin
    pump_running_nxt = pump_running_r;
    settling_nxt     = settling_r;
    last_check_nxt   = last_check_r;
    start_time_nxt   = start_time_r;
    stop_time_nxt    = stop_time_r;
    last_water_nxt   = last_water_r;
    pct_nxt          = pct_r;
    sampled_nxt      = sampled_r;
    event_nxt        = event_r;
    if (cmd.eval && settling_r && go) begin
      settling_nxt = 1'b0;
    end
    if (cmd.decide) begin
      pct_nxt     = new_pct;
      sampled_nxt = br_run_r || br_check_r;
      event_nxt   = EV_NONE;
      if (br_run_r) begin
        if (new_pct >= cfg.wet_threshold) begin
          event_nxt = EV_STOP_WET;
        end else if (elapsed(now_r, start_time_r) >= cfg.burst_duration_ms) begin
          event_nxt = EV_STOP_BURST;
        end
        if (event_nxt != EV_NONE) begin
          pump_running_nxt = 1'b0;
          settling_nxt     = 1'b1;
          stop_time_nxt    = now_r;
          last_water_nxt   = now_r;
        end
      end else if (br_check_r) begin
        last_check_nxt = now_r;
        if (new_pct <= cfg.dry_threshold &&
            elapsed(now_r, last_water_r) >= cfg.cooldown_ms &&
            elapsed(now_r, stop_time_r) >= MIN_PUMP_OFF_MS) begin
          pump_running_nxt = 1'b1;
          start_time_nxt   = now_r;
          event_nxt        = EV_START;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_running_r <= 1'b0;
      settling_r     <= 1'b0;
      last_check_r   <= '0;
      start_time_r   <= '0;
      stop_time_r    <= '0;
      last_water_r   <= '0;
      pct_r          <= '0;
      sampled_r      <= 1'b0;
      event_r        <= EV_NONE;
    end else begin
      pump_running_r <= pump_running_nxt;
      settling_r     <= settling_nxt;
      last_check_r   <= last_check_nxt;
      start_time_r   <= start_time_nxt;
      stop_time_r    <= stop_time_nxt;
      last_water_r   <= last_water_nxt;
      pct_r          <= pct_nxt;
      sampled_r      <= sampled_nxt;
      event_r        <= event_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_current_time;
      raw_r <= in_moisture_raw;
    end
    if (cmd.eval) begin
      br_run_r   <= br_run_nxt;
      br_check_r <= br_check_nxt;
    end
    if (cmd.mul) begin
      zero_r <= (d_diff == '0) || (n_diff == '0) || (n_diff[DIFF_W-1] != d_diff[DIFF_W-1]);
      full_r <= n_abs >= d_abs;
      dabs_r <= d_abs;
    end
    if (cmd.mul || cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign res.pump_on          = pump_running_r;
  assign res.sampled          = sampled_r;
  assign res.moisture_percent = pct_r;
  assign res.pump_event       = event_r;

endmodule

/* rtl/core/soil_moisture_pump_controller_top.sv */
// Soil moisture pump controller. Each input word is one tick: a millisecond
// timestamp and a raw moisture sample; each tick yields exactly one output word
// with the pump level, whether moisture was sampled, the last moisture percent
// in Q7.8 and the pump event. A tick that samples moisture passes through the
// 15-step restoring divider that maps raw readings to percent; a tick without
// a sample skips it. One tick is processed at a time, and the next tick is
// accepted while the previous output word is still held in the output register.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must do so while no tick is in flight, as the block does not enforce it.
module soil_moisture_pump_controller_top import smpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_W-1:0]    in_current_time,
  input  logic [SAMPLE_W-1:0]  in_moisture_raw,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_pump_on,
  output logic                 out_sampled,
  output logic [PCT_W-1:0]     out_moisture_percent,
  output logic [1:0]           out_pump_event,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  sts_t sts;
  res_t res;
  res_t out_r;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SETTLING: cfg_nxt.settling_delay_ms = cfg_data[TIME_W-1:0];
        CFG_CHECK:    cfg_nxt.check_interval_ms = cfg_data[TIME_W-1:0];
        CFG_BURST:    cfg_nxt.burst_duration_ms = cfg_data[TIME_W-1:0];
        CFG_COOLDOWN: cfg_nxt.cooldown_ms       = cfg_data[TIME_W-1:0];
        CFG_DRY:      cfg_nxt.dry_threshold     = cfg_data[PCT_W-1:0];
        CFG_WET:      cfg_nxt.wet_threshold     = cfg_data[PCT_W-1:0];
        CFG_AIR:      cfg_nxt.air_reading       = cfg_data[SAMPLE_W-1:0];
        CFG_WATER:    cfg_nxt.water_reading     = cfg_data[SAMPLE_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settling_delay_ms <= RST_SETTLING;
      cfg_r.check_interval_ms <= RST_CHECK;
      cfg_r.burst_duration_ms <= RST_BURST;
      cfg_r.cooldown_ms       <= RST_COOLDOWN;
      cfg_r.dry_threshold     <= RST_DRY;
      cfg_r.wet_threshold     <= RST_WET;
      cfg_r.air_reading       <= RST_AIR;
      cfg_r.water_reading     <= RST_WATER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  smpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  smpc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg_r),
    .in_current_time (in_current_time),
    .in_moisture_raw (in_moisture_raw),
    .sts             (sts),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res;
    end
  end

  assign in_stall             = !cmd.idle;
  assign out_valid            = out_valid_r;
  assign out_pump_on          = out_r.pump_on;
  assign out_sampled          = out_r.sampled;
  assign out_moisture_percent = out_r.moisture_percent;
  assign out_pump_event       = out_r.pump_event;

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pump_event == EV_START |-> out_pump_on)
    else $error("Pump start reported with pump off.");

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pump_event == EV_STOP_WET || out_pump_event == EV_STOP_BURST)
    |-> !out_pump_on)
    else $error("Pump stop reported with pump on.");

  a_event_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pump_event != EV_NONE |-> out_sampled)
    else $error("Pump event reported without a moisture sample.");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_moisture_percent <= FULL_SCALE)
    else $error("Moisture percent above full scale.");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import smpc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [TIME_W-1:0]   now;
    logic [SAMPLE_W-1:0] raw;
  } tick_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_current_time = '0;
  logic [SAMPLE_W-1:0]  in_moisture_raw = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_pump_on;
  logic                 out_sampled;
  logic [PCT_W-1:0]     out_moisture_percent;
  logic [1:0]           out_pump_event;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  soil_moisture_pump_controller_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_current_time      (in_current_time),
    .in_moisture_raw      (in_moisture_raw),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_pump_on          (out_pump_on),
    .out_sampled          (out_sampled),
    .out_moisture_percent (out_moisture_percent),
    .out_pump_event       (out_pump_event),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  cfg_t shadow_cfg = '{
    settling_delay_ms: RST_SETTLING,
    check_interval_ms: RST_CHECK,
    burst_duration_ms: RST_BURST,
    cooldown_ms:       RST_COOLDOWN,
    dry_threshold:     RST_DRY,
    wet_threshold:     RST_WET,
    air_reading:       RST_AIR,
    water_reading:     RST_WATER
  };

  logic              pump_running = 1'b0;
  logic              settling = 1'b0;
  logic [TIME_W-1:0] check_ms = '0;
  logic [TIME_W-1:0] start_ms = '0;
  logic [TIME_W-1:0] stop_ms = '0;
  logic [TIME_W-1:0] water_ms = '0;
  logic [PCT_W-1:0]  pct_held = '0;

  tick_t tick_backlog[$];
  res_t  due_words[$];

  int errors = 0;
  int ticks_sent = 0;
  int words_seen = 0;
  int samples_due = 0;
  int starts_due = 0;
  int stops_due = 0;
  int settings_used = 1;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [TIME_W-1:0] gen_ms = '0;

  function automatic logic [TIME_W-1:0] since_ms(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return a - b;
  endfunction

  function automatic logic [PCT_W-1:0] raw_to_pct(logic [SAMPLE_W-1:0] raw);
    longint x, a, w, p;
    x = longint'(raw);
    a = longint'(shadow_cfg.air_reading);
    w = longint'(shadow_cfg.water_reading);
    p = 0;
    if (w != a) begin
      p = ((x - a) * 25600) / (w - a);
      if (p < 0) p = 0;
      if (p > 25600) p = 25600;
    end
    return p[PCT_W-1:0];
  endfunction

  task automatic stop_pump(input logic [TIME_W-1:0] now);
    pump_running = 1'b0;
    stop_ms = now;
    settling = 1'b1;
    water_ms = now;
    stops_due++;
  endtask

  task automatic step_controller(input logic [TIME_W-1:0] now, input logic [SAMPLE_W-1:0] raw,
                                 output res_t word);
    logic        go;
    logic        smp;
    pump_event_t ev;
    go = 1'b1;
    smp = 1'b0;
    ev = EV_NONE;
    if (settling) begin
      if (since_ms(now, stop_ms) < shadow_cfg.settling_delay_ms) go = 1'b0;
      else settling = 1'b0;
    end
    if (go && pump_running) begin
      pct_held = raw_to_pct(raw);
      smp = 1'b1;
      if (pct_held >= shadow_cfg.wet_threshold) begin
        stop_pump(now);
        ev = EV_STOP_WET;
      end else if (since_ms(now, start_ms) >= shadow_cfg.burst_duration_ms) begin
        stop_pump(now);
        ev = EV_STOP_BURST;
      end
    end else if (go && since_ms(now, check_ms) >= shadow_cfg.check_interval_ms) begin
      check_ms = now;
      pct_held = raw_to_pct(raw);
      smp = 1'b1;
      if (pct_held <= shadow_cfg.dry_threshold &&
          since_ms(now, water_ms) >= shadow_cfg.cooldown_ms &&
          since_ms(now, stop_ms) >= MIN_PUMP_OFF_MS) begin
        pump_running = 1'b1;
        start_ms = now;
        ev = EV_START;
        starts_due++;
      end
    end
    if (smp) samples_due++;
    word.pump_on = pump_running;
    word.sampled = smp;
    word.moisture_percent = pct_held;
    word.pump_event = ev;
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Sender: one tick word on the input channel, held while stalled.
  always @(posedge clk) begin : drive_ticks
    res_t  want;
    tick_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_controller(in_current_time, in_moisture_raw, want);
        due_words.push_back(want);
        ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          t = tick_backlog.pop_front();
          in_valid <= 1'b1;
          in_current_time <= t.now;
          in_moisture_raw <= t.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual pump %0b sampled %0b pct %0d ev %0d",
                   $time, out_pump_on, out_sampled, out_moisture_percent, out_pump_event);
        end else begin
          want = due_words.pop_front();
          compare_field("pump_on", 32'(want.pump_on), 32'(out_pump_on));
          compare_field("sampled", 32'(want.sampled), 32'(out_sampled));
          compare_field("moisture_percent", 32'(want.moisture_percent),
                        32'(out_moisture_percent));
          compare_field("pump_event", 32'(want.pump_event), 32'(out_pump_event));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still due", $time, due_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SETTLING: shadow_cfg.settling_delay_ms = val;
      CFG_CHECK:    shadow_cfg.check_interval_ms = val;
      CFG_BURST:    shadow_cfg.burst_duration_ms = val;
      CFG_COOLDOWN: shadow_cfg.cooldown_ms = val;
      CFG_DRY:      shadow_cfg.dry_threshold = val[PCT_W-1:0];
      CFG_WET:      shadow_cfg.wet_threshold = val[PCT_W-1:0];
      CFG_AIR:      shadow_cfg.air_reading = val[SAMPLE_W-1:0];
      CFG_WATER:    shadow_cfg.water_reading = val[SAMPLE_W-1:0];
      default:      ;
    endcase
  endtask

  task automatic program_all(input logic [31:0] settle, input logic [31:0] check,
                             input logic [31:0] burst, input logic [31:0] cool,
                             input logic [31:0] dry, input logic [31:0] wet,
                             input logic [31:0] air, input logic [31:0] water);
    write_reg(CFG_SETTLING, settle);
    write_reg(CFG_CHECK, check);
    write_reg(CFG_BURST, burst);
    write_reg(CFG_COOLDOWN, cool);
    write_reg(CFG_DRY, dry);
    write_reg(CFG_WET, wet);
    write_reg(CFG_AIR, air);
    write_reg(CFG_WATER, water);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return $urandom;
      2, 3:    return $urandom_range(5000, 12000);
      default: return $urandom_range(1, 120);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_step();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 8);
      6, 7:    return shadow_cfg.check_interval_ms + $urandom_range(0, 2) - 1;
      8:       return shadow_cfg.settling_delay_ms + $urandom_range(0, 2) - 1;
      9:       return shadow_cfg.burst_duration_ms + $urandom_range(0, 2) - 1;
      10:      return shadow_cfg.cooldown_ms + $urandom_range(0, 2) - 1;
      11:      return MIN_PUMP_OFF_MS + $urandom_range(0, 2) - 1;
      12:      return $urandom_range(0, 200);
      13:      return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_raw();
    case ($urandom_range(0, 15))
      8:       return shadow_cfg.air_reading;
      9:       return shadow_cfg.water_reading;
      10:      return '0;
      11:      return '1;
      12, 13, 14, 15:
        return SAMPLE_W'($urandom_range(shadow_cfg.air_reading, shadow_cfg.water_reading));
      default: return SAMPLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic queue_tick(input logic [TIME_W-1:0] now, input logic [SAMPLE_W-1:0] raw);
    tick_t t;
    t.now = now;
    t.raw = raw;
    tick_backlog.push_back(t);
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      gen_ms = gen_ms + pick_step();
      queue_tick(gen_ms, pick_raw());
    end
  endtask

  task automatic drain();
    while (tick_backlog.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    if (phase < 4) begin
      send_idle_pct = 25;
      recv_idle_pct = 58;
    end else if (phase < 8) begin
      send_idle_pct = 58;
      recv_idle_pct = 25;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: check boundary, start, burst end, settling, wet stop, time wrap.
    set_idling(0);
    queue_tick(32'd0, 10'd0);
    queue_tick(32'd3599999, 10'd1023);
    queue_tick(32'd3600000, 10'd1023);
    queue_tick(32'd3600001, 10'd550);
    queue_tick(32'd3603000, 10'd400);
    queue_tick(32'd3603001, 10'h2AA);
    queue_tick(32'd3617999, 10'h155);
    queue_tick(32'd3618000, 10'd275);
    queue_tick(32'd7218000, 10'd275);
    queue_tick(32'd10818000, 10'd550);
    queue_tick(32'd10818001, 10'd275);
    queue_tick(32'd10818002, 10'd512);
    queue_tick(32'hFFFF_FFFF, 10'd1023);
    queue_tick(32'h0000_0005, 10'd300);
    gen_ms = 32'h0000_0005;
    drain();

    set_idling(1);
    program_all(20, 10, 40, 60, 12800, 19200, 800, 300);
    queue_random(200);
    drain();

    set_idling(2);
    program_all(0, 0, 0, 0, 0, 0, 0, 1023);
    queue_random(60);
    drain();

    set_idling(3);
    program_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h7FFF, 32'h7FFF, 1023, 0);
    queue_random(60);
    drain();

    set_idling(4);
    program_all(5, 3, 20, 0, 12800, 12800, 512, 512);
    queue_random(60);
    drain();

    set_idling(5);
    program_all(10, 5, 50, 30, 25600, 25600, 100, 900);
    queue_random(120);
    drain();

    for (int phase = 6; phase < 11; phase++) begin
      set_idling(phase);
      program_all(pick_span(), pick_span(), pick_span(), pick_span(),
                  $urandom_range(0, 25600), $urandom_range(0, 25600),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
      queue_random(120);
      drain();
    end

    $display("Checked %0d of %0d tick words over %0d register settings.",
             words_seen, ticks_sent, settings_used);
    $display("Those ticks took %0d samples, %0d pump starts and %0d pump stops.",
             samples_due, starts_due, stops_due);
    if (errors == 0 && due_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/smpc_pkg.sv
rtl/core/smpc_ctrl.sv
rtl/core/smpc_dp.sv
rtl/core/soil_moisture_pump_controller_top.sv
bench/testbench.sv
